// ===== hdl/one_wire_slot_engine_defines.svh =====
// Assertion macros shared by the checker files of the 1-Wire slot engine.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef ONE_WIRE_SLOT_ENGINE_DEFINES_SVH
`define ONE_WIRE_SLOT_ENGINE_DEFINES_SVH

// Clocked check, muted while reset is asserted
`define OWSE_CHK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset
`define OWSE_CHK_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/owse_pkg.sv =====
// Package of the 1-Wire slot engine: word types, command and phase codes,
// configuration indexes and reset values. Depends on nothing.
package owse_pkg;

  // Input kind codes as seen on the input word
  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_RESET = 3'd1;
  localparam logic [2:0] KIND_WBIT  = 3'd2;
  localparam logic [2:0] KIND_RBIT  = 3'd3;
  localparam logic [2:0] KIND_WBYTE = 3'd4;
  localparam logic [2:0] KIND_RBYTE = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] CFG_RESET_RECOVER = 3'd2;
  localparam logic [2:0] CFG_SLOT_LOW      = 3'd3;
  localparam logic [2:0] CFG_WRITE_SLOT    = 3'd4;
  localparam logic [2:0] CFG_READ_SAMPLE   = 3'd5;
  localparam logic [2:0] CFG_READ_REST     = 3'd6;

  // Register reset values
  localparam logic [9:0] RST_RESET_LOW     = 10'd480;
  localparam logic [9:0] RST_PRESENCE_WAIT = 10'd60;
  localparam logic [9:0] RST_RESET_RECOVER = 10'd420;
  localparam logic [7:0] RST_SLOT_LOW      = 8'd1;
  localparam logic [7:0] RST_WRITE_SLOT    = 8'd60;
  localparam logic [7:0] RST_READ_SAMPLE   = 8'd14;
  localparam logic [7:0] RST_READ_REST     = 8'd45;

  localparam int CFG_DATA_W  = 10;
  localparam int COUNT_W_DEF = 10;
  localparam int SAT_W       = 17;  // holds the counter max for any width up to 16
  localparam int Q_DEPTH     = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_data;
    logic       line_in;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       presence_level;
    logic       rejected;
  } out_item_t;

  // Classified command carried from front to back
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_RESET,
    CMD_WBIT,
    CMD_RBIT,
    CMD_WBYTE,
    CMD_RBYTE
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_data;
    logic       line_in;
  } q_entry_t;

  // Status of the queue as the front sees it
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_RECOVER,
    PH_SLOT_LOW,
    PH_WRITE_REST,
    PH_READ_WAIT,
    PH_READ_REST
  } phase_t;

endpackage

// ===== hdl/one_wire_slot_engine.sv =====
// 1-Wire bus master slot engine, top level.
// Instantiates owse_front, owse_queue and owse_back; uses owse_pkg.
//
// Usage:
//   in_*  : one word per microsecond tick or command (reset, bit or byte
//           read/write). Each accepted word gives exactly one out_* word
//           with the bus drive, busy/done flags, read data, presence level
//           and a reject flag for commands that arrive while busy.
//   cfg_* : writes the seven timing registers; cfg_ready is always high.
//           Write only while the engine is idle and the pipeline is empty.
//   Throughput: one word per cycle while out_ready is high. The phase
//   sequencer in the back end handles one word per cycle when not stalled;
//   a two-entry queue decouples it from the front stage, so in_ready
//   depends only on registered queue state. A word passes the front stage
//   register, a queue entry and the output word register to reach out_*.
//   Stall: when out_ready is low the result word holds, the back end
//   stops and the queue fills; in_ready drops once four words wait (the
//   result word, two queue entries and the front stage).
//   Reset (rst_n low, synchronous): pipeline emptied, engine idle,
//   timing registers back to 480/60/420/1/60/14/45, presence level 1.
module one_wire_slot_engine #(
  parameter int COUNT_WIDTH = owse_pkg::COUNT_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  owse_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output owse_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [2:0]                      cfg_index,
  input  logic [owse_pkg::CFG_DATA_W-1:0] cfg_data
);

  owse_pkg::q_stat_t  q_stat;
  owse_pkg::q_entry_t q_wdata, q_rdata;
  logic               q_push, q_pop;

  assign cfg_ready = 1'b1;

  owse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  owse_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .stat  (q_stat),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  owse_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_stat.empty),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== hdl/owse_front.sv =====
// Front stage of the 1-Wire slot engine: accepts input words and classifies
// the kind code into a command. Depends on owse_pkg.
module owse_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  owse_pkg::in_item_t in_item,
  input  owse_pkg::q_stat_t  q_stat,
  output logic               q_push,
  output owse_pkg::q_entry_t q_wdata
);

  logic               f_valid_r, f_valid_nxt;
  owse_pkg::q_entry_t f_entry_r;
  owse_pkg::cmd_t     cmd;
  logic               in_fire;

  // Stage register frees whenever the queue has room
  assign q_push   = f_valid_r && !q_stat.full;
  assign in_ready = !f_valid_r || !q_stat.full;
  assign in_fire  = in_valid && in_ready;
  assign q_wdata  = f_entry_r;

  // Kind decode; codes 6 and 7 do nothing
  always_comb begin
    unique case (in_item.kind)
      owse_pkg::KIND_TICK:  cmd = owse_pkg::CMD_TICK;
      owse_pkg::KIND_RESET: cmd = owse_pkg::CMD_RESET;
      owse_pkg::KIND_WBIT:  cmd = owse_pkg::CMD_WBIT;
      owse_pkg::KIND_RBIT:  cmd = owse_pkg::CMD_RBIT;
      owse_pkg::KIND_WBYTE: cmd = owse_pkg::CMD_WBYTE;
      owse_pkg::KIND_RBYTE: cmd = owse_pkg::CMD_RBYTE;
      default:              cmd = owse_pkg::CMD_NOP;
    endcase
  end

  assign f_valid_nxt = in_fire || (f_valid_r && q_stat.full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      f_entry_r.cmd     <= cmd;
      f_entry_r.tx_data <= in_item.tx_data;
      f_entry_r.line_in <= in_item.line_in;
    end
  end

endmodule

// ===== hdl/owse_queue.sv =====
// Two-entry queue between front and back of the 1-Wire slot engine.
// Depends on owse_pkg.
module owse_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  owse_pkg::q_entry_t wdata,
  output owse_pkg::q_stat_t  stat,
  input  logic               pop,
  output owse_pkg::q_entry_t rdata
);

  localparam int PW = $clog2(owse_pkg::Q_DEPTH);
  localparam int CW = $clog2(owse_pkg::Q_DEPTH + 1);

  owse_pkg::q_entry_t entry_r [owse_pkg::Q_DEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CW'(owse_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(owse_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(owse_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/owse_back.sv =====
// Back end of the 1-Wire slot engine: timing registers, phase sequencer,
// tick counter, shift register and the output word register. Uses owse_pkg.
module owse_back #(
  parameter int COUNT_WIDTH = owse_pkg::COUNT_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  owse_pkg::q_entry_t                q_rdata,
  input  logic                              cfg_valid,
  input  logic [2:0]                        cfg_index,
  input  logic [owse_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output owse_pkg::out_item_t               out_item
);

  localparam int CW = COUNT_WIDTH;
  localparam logic [owse_pkg::SAT_W-1:0] CNT_MAX =
    owse_pkg::SAT_W'((1 << COUNT_WIDTH) - 1);

  // Timing registers
  logic [9:0] reset_low_r, presence_wait_r, reset_recover_r;
  logic [7:0] slot_low_r, write_slot_r, read_sample_r, read_rest_r;

  // Engine state
  owse_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [3:0]       bits_r, bits_nxt, bits_dec;
  logic             op_rd_r, op_rd_nxt;
  logic             op_byte_r, op_byte_nxt;
  logic             pres_r, pres_nxt;

  logic                     out_valid_r;
  owse_pkg::out_item_t      out_item_r, res;
  logic                     fire;
  logic                     done, rej, was_read, was_byte, busy;
  logic                     ld_en;
  logic [2:0]               ld_sel;
  logic [9:0]               ld_raw;
  logic [owse_pkg::SAT_W-1:0] ld_ext;
  logic [7:0]               rx;
  logic                     drive;

  // One queued word is processed per cycle while the output can take it
  assign fire      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign busy      = (phase_r != owse_pkg::PH_IDLE);

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= owse_pkg::RST_RESET_LOW;
      presence_wait_r <= owse_pkg::RST_PRESENCE_WAIT;
      reset_recover_r <= owse_pkg::RST_RESET_RECOVER;
      slot_low_r      <= owse_pkg::RST_SLOT_LOW;
      write_slot_r    <= owse_pkg::RST_WRITE_SLOT;
      read_sample_r   <= owse_pkg::RST_READ_SAMPLE;
      read_rest_r     <= owse_pkg::RST_READ_REST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        owse_pkg::CFG_RESET_LOW:     reset_low_r     <= cfg_data;
        owse_pkg::CFG_PRESENCE_WAIT: presence_wait_r <= cfg_data;
        owse_pkg::CFG_RESET_RECOVER: reset_recover_r <= cfg_data;
        owse_pkg::CFG_SLOT_LOW:      slot_low_r      <= cfg_data[7:0];
        owse_pkg::CFG_WRITE_SLOT:    write_slot_r    <= cfg_data[7:0];
        owse_pkg::CFG_READ_SAMPLE:   read_sample_r   <= cfg_data[7:0];
        owse_pkg::CFG_READ_REST:     read_rest_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Phase sequencer: next state and result word
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    shift_nxt   = shift_r;
    bits_nxt    = bits_r;
    op_rd_nxt   = op_rd_r;
    op_byte_nxt = op_byte_r;
    pres_nxt    = pres_r;
    done        = 1'b0;
    rej         = 1'b0;
    was_read    = 1'b0;
    was_byte    = 1'b0;
    ld_en       = 1'b0;
    ld_sel      = owse_pkg::CFG_RESET_LOW;
    bits_dec    = (bits_r != 4'd0) ? bits_r - 4'd1 : 4'd0;

    if (fire) begin
      unique case (q_rdata.cmd) inside
        owse_pkg::CMD_TICK: begin
          if (busy) begin
            if (cnt_r > CW'(1)) begin
              cnt_nxt = cnt_r - CW'(1);
            end else begin
              was_read = op_rd_r;
              was_byte = op_byte_r;
              unique case (phase_r)
                owse_pkg::PH_RST_LOW: begin
                  phase_nxt = owse_pkg::PH_RST_WAIT;
                  ld_en     = 1'b1;
                  ld_sel    = owse_pkg::CFG_PRESENCE_WAIT;
                end
                owse_pkg::PH_RST_WAIT: begin
                  pres_nxt  = q_rdata.line_in;
                  phase_nxt = owse_pkg::PH_RST_RECOVER;
                  ld_en     = 1'b1;
                  ld_sel    = owse_pkg::CFG_RESET_RECOVER;
                end
                owse_pkg::PH_RST_RECOVER: begin
                  phase_nxt = owse_pkg::PH_IDLE;
                  cnt_nxt   = '0;
                  done      = 1'b1;
                  was_read  = 1'b0;
                end
                owse_pkg::PH_SLOT_LOW: begin
                  phase_nxt = op_rd_r ? owse_pkg::PH_READ_WAIT : owse_pkg::PH_WRITE_REST;
                  ld_en     = 1'b1;
                  ld_sel    = op_rd_r ? owse_pkg::CFG_READ_SAMPLE : owse_pkg::CFG_WRITE_SLOT;
                end
                owse_pkg::PH_READ_WAIT: begin
                  shift_nxt = {q_rdata.line_in, shift_r[7:1]};
                  phase_nxt = owse_pkg::PH_READ_REST;
                  ld_en     = 1'b1;
                  ld_sel    = owse_pkg::CFG_READ_REST;
                end
                owse_pkg::PH_WRITE_REST, owse_pkg::PH_READ_REST: begin
                  // end of a bit slot: next slot of the byte or finish
                  if (!op_rd_r) begin
                    shift_nxt = {1'b0, shift_r[7:1]};
                  end
                  bits_nxt = bits_dec;
                  if (bits_dec != 4'd0) begin
                    phase_nxt = owse_pkg::PH_SLOT_LOW;
                    ld_en     = 1'b1;
                    ld_sel    = owse_pkg::CFG_SLOT_LOW;
                  end else begin
                    phase_nxt = owse_pkg::PH_IDLE;
                    cnt_nxt   = '0;
                    done      = 1'b1;
                  end
                end
                owse_pkg::PH_IDLE: ;
                default: ;
              endcase
            end
          end
        end
        owse_pkg::CMD_RESET: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            op_rd_nxt   = 1'b0;
            op_byte_nxt = 1'b0;
            bits_nxt    = 4'd0;
            phase_nxt   = owse_pkg::PH_RST_LOW;
            ld_en       = 1'b1;
            ld_sel      = owse_pkg::CFG_RESET_LOW;
          end
        end
        owse_pkg::CMD_WBIT, owse_pkg::CMD_RBIT, owse_pkg::CMD_WBYTE, owse_pkg::CMD_RBYTE: begin
          if (busy) begin
            rej = 1'b1;
          end else begin
            op_rd_nxt   = (q_rdata.cmd == owse_pkg::CMD_RBIT) ||
                          (q_rdata.cmd == owse_pkg::CMD_RBYTE);
            op_byte_nxt = (q_rdata.cmd == owse_pkg::CMD_WBYTE) ||
                          (q_rdata.cmd == owse_pkg::CMD_RBYTE);
            bits_nxt    = op_byte_nxt ? 4'd8 : 4'd1;
            if (op_rd_nxt) begin
              shift_nxt = 8'd0;
            end else if (op_byte_nxt) begin
              shift_nxt = q_rdata.tx_data;
            end else begin
              shift_nxt = {7'd0, q_rdata.tx_data[0]};
            end
            phase_nxt = owse_pkg::PH_SLOT_LOW;
            ld_en     = 1'b1;
            ld_sel    = owse_pkg::CFG_SLOT_LOW;
          end
        end
        default: ;
      endcase
    end

    // Counter load from the selected timing register, saturated to the counter
    unique case (ld_sel)
      owse_pkg::CFG_RESET_LOW:     ld_raw = reset_low_r;
      owse_pkg::CFG_PRESENCE_WAIT: ld_raw = presence_wait_r;
      owse_pkg::CFG_RESET_RECOVER: ld_raw = reset_recover_r;
      owse_pkg::CFG_SLOT_LOW:      ld_raw = {2'b00, slot_low_r};
      owse_pkg::CFG_WRITE_SLOT:    ld_raw = {2'b00, write_slot_r};
      owse_pkg::CFG_READ_SAMPLE:   ld_raw = {2'b00, read_sample_r};
      owse_pkg::CFG_READ_REST:     ld_raw = {2'b00, read_rest_r};
      default:                     ld_raw = 10'd0;
    endcase
    ld_ext = owse_pkg::SAT_W'(ld_raw);
    if (ld_en) begin
      cnt_nxt = (ld_ext > CNT_MAX) ? CNT_MAX[CW-1:0] : ld_ext[CW-1:0];
    end

    // Read data shows only on the word that finishes a read
    rx = 8'd0;
    if (done && was_read) begin
      rx = was_byte ? shift_nxt : {7'd0, shift_nxt[7]};
    end

    // Bus drive after this word
    unique case (phase_nxt)
      owse_pkg::PH_RST_LOW, owse_pkg::PH_SLOT_LOW: drive = 1'b1;
      owse_pkg::PH_WRITE_REST:                     drive = ~shift_nxt[0];
      default:                                     drive = 1'b0;
    endcase

    res.drive_low      = drive;
    res.busy_res       = (phase_nxt != owse_pkg::PH_IDLE);
    res.done_res       = done;
    res.rx_data        = rx;
    res.presence_level = pres_nxt;
    res.rejected       = rej;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= owse_pkg::PH_IDLE;
      cnt_r       <= '0;
      shift_r     <= 8'd0;
      bits_r      <= 4'd0;
      op_rd_r     <= 1'b0;
      op_byte_r   <= 1'b0;
      pres_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      bits_r      <= bits_nxt;
      op_rd_r     <= op_rd_nxt;
      op_byte_r   <= op_byte_nxt;
      pres_r      <= pres_nxt;
      out_valid_r <= fire || (out_valid_r && !out_ready);
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

endmodule

// ===== hdl/owse_checker.sv =====
// Port-level checks for the 1-Wire slot engine, bound to the top level.
// Depends on owse_pkg and one_wire_slot_engine_defines.svh.
`include "one_wire_slot_engine_defines.svh"

module owse_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input owse_pkg::out_item_t out_item
);

  // A stalled result word holds
  `OWSE_CHK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "result word changed while stalled")

  // No word is both a tick that finishes and a rejected command
  `OWSE_CHK(a_done_rej, out_valid |-> !(out_item.done_res && out_item.rejected), "done and rejected on one word")

  // Read data is zero except on a finishing word
  `OWSE_CHK(a_rx_zero, out_valid && !out_item.done_res |-> out_item.rx_data == 8'd0, "read data without done")

  // Finishing leaves the engine idle and the bus released
  `OWSE_CHK(a_done_idle, out_valid && out_item.done_res |-> !out_item.busy_res && !out_item.drive_low, "busy after done")

  // Reset empties the output
  `OWSE_CHK_RST(a_rst_empty, !rst_n |=> !out_valid, "result word valid after reset")

endmodule

bind one_wire_slot_engine owse_checker u_owse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ===== test/tb.sv =====
// Self-checking testbench of the 1-Wire slot engine: drives tick and command words,
// predicts every status word in step with the engine and checks each one.
// Depends on owse_pkg and one_wire_slot_engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [2:0] CFG_UNUSED    = 3'd7;
  localparam int unsigned RUN_LIMIT    = 300000;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_REPORTS = 200;

  logic                obsolete_unused_never;
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  owse_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  owse_pkg::out_item_t out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [owse_pkg::CFG_DATA_W-1:0] cfg_data;

  // Shared control between the stimulus, the result sink and the checker
  bit quiet;
  bit hold_req;
  int fails = 0;
  int unsigned cycles = 0;
  owse_pkg::out_item_t pending_status[$];

  // Shadow copy of the engine state and timing registers
  logic [9:0]       timing [7];
  owse_pkg::phase_t eng_phase;
  logic [9:0]       eng_count;
  logic [7:0]       eng_shift;
  logic [3:0]       eng_bits;
  logic             eng_rd;
  logic             eng_byte;
  logic             eng_presence;

  one_wire_slot_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Engine prediction
  // ---------------------------------------------------------------------------

  // Load a phase and its duration; 10-bit registers never exceed the counter max
  function automatic void enter_phase(owse_pkg::phase_t p, logic [2:0] idx);
    eng_phase = p;
    eng_count = timing[idx];
  endfunction

  // End of one bit slot: next slot of a byte, or the operation is done
  function automatic logic close_slot();
    if (!eng_rd) eng_shift = eng_shift >> 1;
    if (eng_bits != 0) eng_bits = eng_bits - 1'b1;
    if (eng_bits != 0) begin
      enter_phase(owse_pkg::PH_SLOT_LOW, owse_pkg::CFG_SLOT_LOW);
      return 1'b0;
    end
    eng_phase = owse_pkg::PH_IDLE;
    eng_count = '0;
    return 1'b1;
  endfunction

  function automatic owse_pkg::out_item_t predict_slot(owse_pkg::in_item_t w);
    owse_pkg::out_item_t r;
    logic done;
    logic was_rd;
    logic was_byte;
    r = '0;
    done = 1'b0;
    was_rd = 1'b0;
    was_byte = 1'b0;
    if (w.kind >= owse_pkg::KIND_RESET && w.kind <= owse_pkg::KIND_RBYTE) begin
      if (eng_phase != owse_pkg::PH_IDLE) begin
        r.rejected = 1'b1;
      end else if (w.kind == owse_pkg::KIND_RESET) begin
        eng_rd = 1'b0;
        eng_byte = 1'b0;
        eng_bits = '0;
        enter_phase(owse_pkg::PH_RST_LOW, owse_pkg::CFG_RESET_LOW);
      end else begin
        eng_rd = (w.kind == owse_pkg::KIND_RBIT || w.kind == owse_pkg::KIND_RBYTE);
        eng_byte = (w.kind == owse_pkg::KIND_WBYTE || w.kind == owse_pkg::KIND_RBYTE);
        eng_bits = eng_byte ? 4'd8 : 4'd1;
        eng_shift = eng_rd ? 8'h00 : (eng_byte ? w.tx_data : {7'b0, w.tx_data[0]});
        enter_phase(owse_pkg::PH_SLOT_LOW, owse_pkg::CFG_SLOT_LOW);
      end
    end else if (w.kind == owse_pkg::KIND_TICK && eng_phase != owse_pkg::PH_IDLE) begin
      if (eng_count > 10'd1) begin
        eng_count = eng_count - 1'b1;
      end else begin
        was_rd = eng_rd;
        was_byte = eng_byte;
        case (eng_phase)
          owse_pkg::PH_RST_LOW:
            enter_phase(owse_pkg::PH_RST_WAIT, owse_pkg::CFG_PRESENCE_WAIT);
          owse_pkg::PH_RST_WAIT: begin
            eng_presence = w.line_in;
            enter_phase(owse_pkg::PH_RST_RECOVER, owse_pkg::CFG_RESET_RECOVER);
          end
          owse_pkg::PH_RST_RECOVER: begin
            eng_phase = owse_pkg::PH_IDLE;
            eng_count = '0;
            done = 1'b1;
            was_rd = 1'b0;
          end
          owse_pkg::PH_SLOT_LOW: begin
            if (eng_rd) enter_phase(owse_pkg::PH_READ_WAIT, owse_pkg::CFG_READ_SAMPLE);
            else enter_phase(owse_pkg::PH_WRITE_REST, owse_pkg::CFG_WRITE_SLOT);
          end
          owse_pkg::PH_READ_WAIT: begin
            // sample enters at bit 7, LSB first on the bus
            eng_shift = {w.line_in, eng_shift[7:1]};
            enter_phase(owse_pkg::PH_READ_REST, owse_pkg::CFG_READ_REST);
          end
          owse_pkg::PH_WRITE_REST, owse_pkg::PH_READ_REST: done = close_slot();
          default: ;
        endcase
      end
    end
    if (done && was_rd) r.rx_data = was_byte ? eng_shift : {7'b0, eng_shift[7]};
    if (eng_phase == owse_pkg::PH_RST_LOW || eng_phase == owse_pkg::PH_SLOT_LOW)
      r.drive_low = 1'b1;
    else if (eng_phase == owse_pkg::PH_WRITE_REST)
      r.drive_low = ~eng_shift[0];
    r.busy_res = (eng_phase != owse_pkg::PH_IDLE);
    r.done_res = done;
    r.presence_level = eng_presence;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = quiet || ($urandom_range(99) >= 36);
    end
  end

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  // Compare each status word with the oldest prediction
  always @(posedge clk) begin : check_results
    owse_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: status word expected none got %0h", $time, out_item);
      end else begin
        want = pending_status.pop_front();
        report_field("drive_low", want.drive_low, out_item.drive_low);
        report_field("busy_res", want.busy_res, out_item.busy_res);
        report_field("done_res", want.done_res, out_item.done_res);
        report_field("rx_data", want.rx_data, out_item.rx_data);
        report_field("presence_level", want.presence_level, out_item.presence_level);
        report_field("rejected", want.rejected, out_item.rejected);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one word after random idle cycles; predict it when accepted
  task automatic send_word(input logic [2:0] k, input logic [7:0] d, input logic l);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 36) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = {k, d, l};
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(predict_slot(in_item));
  endtask

  // Tick until the shadow engine is idle; line fixed or random per tick
  task automatic finish_op(input logic l, input bit scramble);
    while (eng_phase != owse_pkg::PH_IDLE)
      send_word(owse_pkg::KIND_TICK, 8'($urandom_range(255)),
                scramble ? 1'($urandom_range(1)) : l);
  endtask

  // Let every expected word arrive before touching the registers
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [9:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    if (idx < CFG_UNUSED) timing[idx] = (idx >= owse_pkg::CFG_SLOT_LOW) ? {2'b0, v[7:0]} : v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_timing(input logic [9:0] rl, input logic [9:0] pw, input logic [9:0] rr,
                             input logic [9:0] sl, input logic [9:0] ws, input logic [9:0] rs,
                             input logic [9:0] rt);
    cfg_write(owse_pkg::CFG_RESET_LOW, rl);
    cfg_write(owse_pkg::CFG_PRESENCE_WAIT, pw);
    cfg_write(owse_pkg::CFG_RESET_RECOVER, rr);
    cfg_write(owse_pkg::CFG_SLOT_LOW, sl);
    cfg_write(owse_pkg::CFG_WRITE_SLOT, ws);
    cfg_write(owse_pkg::CFG_READ_SAMPLE, rs);
    cfg_write(owse_pkg::CFG_READ_REST, rt);
  endtask

  // Mostly complete operations with random data and line levels, plus
  // commands while busy, idle ticks and spare kinds as noise
  task automatic random_traffic(input int n);
    int cnt;
    int r;
    logic [2:0] k;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (eng_phase == owse_pkg::PH_IDLE) begin
        if (r < 85) k = 3'($urandom_range(owse_pkg::KIND_RESET, owse_pkg::KIND_RBYTE));
        else if (r < 93) k = owse_pkg::KIND_TICK;
        else k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        if (k >= owse_pkg::KIND_RESET && k <= owse_pkg::KIND_RBYTE) cnt++;
      end else begin
        if (r < 90) k = owse_pkg::KIND_TICK;
        else if (r < 97) k = 3'($urandom_range(owse_pkg::KIND_RESET, owse_pkg::KIND_RBYTE));
        else k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        if (k == owse_pkg::KIND_TICK) cnt++;
      end
      send_word(k, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle engine ignores ticks and spare kinds; one write slot at reset timing
  task automatic test_power_up_state();
    send_word(owse_pkg::KIND_TICK, 8'h00, 1'b0);
    send_word(owse_pkg::KIND_TICK, 8'hFF, 1'b1);
    send_word(KIND_SPARE_LO, 8'hFF, 1'b1);
    send_word(KIND_SPARE_HI, 8'h00, 1'b0);
    send_word(owse_pkg::KIND_WBIT, 8'h01, 1'b1);
    finish_op(1'b1, 1'b0);
  endtask

  // Every command twice at the shortest timing
  task automatic test_each_command();
    settle();
    load_timing(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
    send_word(owse_pkg::KIND_RESET, 8'h00, 1'b0);
    finish_op(1'b0, 1'b0);
    send_word(owse_pkg::KIND_RESET, 8'hFF, 1'b1);
    finish_op(1'b1, 1'b0);
    send_word(owse_pkg::KIND_WBIT, 8'hFE, 1'b0);
    finish_op(1'b0, 1'b0);
    send_word(owse_pkg::KIND_WBIT, 8'h01, 1'b1);
    finish_op(1'b1, 1'b0);
    send_word(owse_pkg::KIND_WBYTE, 8'hA5, 1'b0);
    finish_op(1'b0, 1'b0);
    send_word(owse_pkg::KIND_WBYTE, 8'h5A, 1'b1);
    finish_op(1'b1, 1'b0);
    send_word(owse_pkg::KIND_RBIT, 8'h00, 1'b0);
    finish_op(1'b1, 1'b0);
    send_word(owse_pkg::KIND_RBIT, 8'hFF, 1'b1);
    finish_op(1'b0, 1'b0);
    send_word(owse_pkg::KIND_RBYTE, 8'h00, 1'b1);
    finish_op(1'b1, 1'b0);
    send_word(owse_pkg::KIND_RBYTE, 8'hFF, 1'b0);
    finish_op(1'b0, 1'b1);
  endtask

  // Commands and spare kinds while a byte is in flight
  task automatic test_busy_commands();
    send_word(owse_pkg::KIND_WBYTE, 8'hFF, 1'b1);
    send_word(owse_pkg::KIND_TICK, 8'h00, 1'b0);
    for (int k = owse_pkg::KIND_RESET; k <= KIND_SPARE_HI; k++)
      send_word(3'(k), 8'hFF, 1'b1);
    finish_op(1'b0, 1'b1);
  endtask

  // Zero durations act as one; 8-bit registers drop the upper data bits;
  // a write to the unused index changes nothing
  task automatic test_zero_and_masked_timing();
    settle();
    load_timing(10'd0, 10'd0, 10'd0, 10'h300, 10'h300, 10'd0, 10'h100);
    cfg_write(CFG_UNUSED, 10'h3FF);
    send_word(owse_pkg::KIND_RESET, 8'h00, 1'b0);
    finish_op(1'b0, 1'b0);
    send_word(owse_pkg::KIND_RBYTE, 8'h00, 1'b0);
    finish_op(1'b0, 1'b1);
    send_word(owse_pkg::KIND_WBYTE, 8'hC3, 1'b1);
    finish_op(1'b1, 1'b1);
  endtask

  // Long result stall while the sender keeps offering words
  task automatic test_backpressure();
    settle();
    load_timing(10'd2, 10'd1, 10'd2, 10'd1, 10'd2, 10'd1, 10'd2);
    quiet = 1'b1;
    hold_req = 1'b1;
    random_traffic(60);
    while (hold_req) @(posedge clk);
    quiet = 1'b0;
  endtask

  // Several rounds of random traffic at random short timings
  task automatic test_random_traffic();
    int hi;
    for (int round = 0; round < 3; round++) begin
      settle();
      hi = (round == 2) ? 20 : 4;
      load_timing(10'($urandom_range(0, hi)), 10'($urandom_range(0, hi)),
                  10'($urandom_range(0, hi)),
                  {2'($urandom_range(3)), 8'($urandom_range(0, hi))},
                  {2'($urandom_range(3)), 8'($urandom_range(0, hi))},
                  {2'($urandom_range(3)), 8'($urandom_range(0, hi))},
                  {2'($urandom_range(3)), 8'($urandom_range(0, hi))});
      quiet = (round == 1);
      random_traffic(220);
      quiet = 1'b0;
    end
  endtask

  // Write slot with its registers at their largest value
  task automatic test_longest_timing();
    settle();
    load_timing(10'd1, 10'd1, 10'd1, 10'h3FF, 10'd255, 10'd1, 10'd1);
    send_word(owse_pkg::KIND_WBIT, 8'h00, 1'b0);
    finish_op(1'b0, 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;

    // shadow state after reset
    timing[owse_pkg::CFG_RESET_LOW] = owse_pkg::RST_RESET_LOW;
    timing[owse_pkg::CFG_PRESENCE_WAIT] = owse_pkg::RST_PRESENCE_WAIT;
    timing[owse_pkg::CFG_RESET_RECOVER] = owse_pkg::RST_RESET_RECOVER;
    timing[owse_pkg::CFG_SLOT_LOW] = {2'b0, owse_pkg::RST_SLOT_LOW};
    timing[owse_pkg::CFG_WRITE_SLOT] = {2'b0, owse_pkg::RST_WRITE_SLOT};
    timing[owse_pkg::CFG_READ_SAMPLE] = {2'b0, owse_pkg::RST_READ_SAMPLE};
    timing[owse_pkg::CFG_READ_REST] = {2'b0, owse_pkg::RST_READ_REST};
    eng_phase = owse_pkg::PH_IDLE;
    eng_count = '0;
    eng_shift = '0;
    eng_bits = '0;
    eng_rd = 1'b0;
    eng_byte = 1'b0;
    eng_presence = 1'b1;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_power_up_state();
    test_each_command();
    test_busy_commands();
    test_zero_and_masked_timing();
    test_backpressure();
    test_random_traffic();
    test_longest_timing();

    settle();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
